// ----- rtl/lrme_pkg.sv -----
`timescale 1ns / 1ps
package lrme_pkg;
	localparam int ROWS_DEF = 64;
	localparam int COLS_DEF = 64;
	localparam int ROD_LEN_DEF = 7;
	localparam int MAX_RODS_DEF = 512;
	localparam int CNT_W = 10;
	localparam int IDX_W = 9;
	localparam int POS_W = 6;

	localparam logic ACT_PLACE = 1'b0;
	localparam logic ACT_MOVE = 1'b1;

	typedef struct packed {
		logic action;
		logic [IDX_W-1:0] rod_index;
		logic [POS_W-1:0] head_row;
		logic [POS_W-1:0] head_col;
		logic place_vertical;
		logic try_rotate;
		logic shift_forward;
	} req_t;

	typedef struct packed {
		logic placed;
		logic rotated;
		logic shifted;
		logic bad_index;
		logic [CNT_W-1:0] horizontal_total;
		logic [CNT_W-1:0] vertical_total;
		logic [CNT_W-1:0] rod_total;
	} rsp_t;
endpackage

// ----- rtl/lrme_stream_if.sv -----
`timescale 1ns / 1ps
interface lrme_stream_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/lrme_ram.sv -----
`timescale 1ns / 1ps
module lrme_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/lattice_rod_move_engine_core.sv -----
`timescale 1ns / 1ps
// Rod move engine on a wrapped ROWS x COLS lattice held in one simple dual-port
// RAM (one read, one write per cycle), addressed as {row, col}. After reset a
// clearing pass writes every lattice RAM entry, 2^($clog2(ROWS)+$clog2(COLS))
// entries (4096 at defaults), during which no item is taken. Each item is worked
// by a sequencer that visits one lattice cell per cycle with registered reads.
// A place reads and checks each rod cell, then writes them. A move may rotate
// (check the new cells, then write them and clear the old ones) and then shift
// (check the leading cell, write it, clear the tail cell); a bad index or a full
// table goes straight to the result. The result sits in an output register; the
// next item is taken once it has been handed off.
module lattice_rod_move_engine_core #(
	parameter int ROWS = lrme_pkg::ROWS_DEF,
	parameter int COLS = lrme_pkg::COLS_DEF,
	parameter int ROD_LEN = lrme_pkg::ROD_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	lrme_stream_if.sink in_ch,
	lrme_stream_if.source out_ch
);
	localparam int MAX_RODS = lrme_pkg::MAX_RODS_DEF;
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam int AW = RW + CW;
	localparam int NC = 1 << AW;
	localparam int TW = $clog2(MAX_RODS + 1);
	localparam int IW = $clog2(MAX_RODS);
	localparam int HALF = ROD_LEN / 2;
	localparam int JW = 6;
	localparam int CNTW = lrme_pkg::CNT_W;
	localparam int HEADS = 1 << lrme_pkg::POS_W;

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_RDROD  = 9'b000000100,
		S_CHECK  = 9'b000001000,
		S_WRITE  = 9'b000010000,
		S_SHCHK  = 9'b000100000,
		S_SHWR   = 9'b001000000,
		S_DONE   = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q;
	lrme_pkg::req_t req_q;
	lrme_pkg::rsp_t rsp_q;
	logic [AW-1:0] clr_q;
	logic [CNTW-1:0] hcnt_q, vcnt_q, rcnt_q;
	logic [RW-1:0] pr_q;
	logic [CW-1:0] pc_q;
	logic vert_q;
	logic signed [JW-1:0] j_q;
	logic pend_q;
	logic blocked_q;
	logic phase_q;
	logic rot_q, sh_q, pl_q;
	logic [IW-1:0] id_q;

	logic cwe;
	logic [AW-1:0] cwa, cra;
	logic [TW-1:0] cwd, crd;
	logic rwe;
	logic [RW+CW:0] rwd, rrd;
	logic [IW-1:0] rra;

	lrme_ram #(.WIDTH(TW), .DEPTH(NC)) u_cell (
		.clk(clk), .we(cwe), .waddr(cwa), .wdata(cwd), .raddr(cra), .rdata(crd)
	);
	lrme_ram #(.WIDTH(RW + CW + 1), .DEPTH(MAX_RODS)) u_rod (
		.clk(clk), .we(rwe), .waddr(id_q), .wdata(rwd), .raddr(rra), .rdata(rrd)
	);

	// offsets stay within +-ROD_LEN, so two corrections cover ROWS, COLS >= 8
	function automatic logic [RW-1:0] wr(input logic [RW-1:0] b, input int off);
		int v;
		v = int'(b) + off;
		for (int k = 0; k < 2; k++) begin
			if (v < 0) v = v + ROWS;
			else if (v >= ROWS) v = v - ROWS;
		end
		return RW'(v);
	endfunction
	function automatic logic [CW-1:0] wc(input logic [CW-1:0] b, input int off);
		int v;
		v = int'(b) + off;
		for (int k = 0; k < 2; k++) begin
			if (v < 0) v = v + COLS;
			else if (v >= COLS) v = v - COLS;
		end
		return CW'(v);
	endfunction

	// cell address for current step
	logic [AW-1:0] addr_c;
	logic [AW-1:0] addr2_c;
	int jv;
	int step_c, lead_c, tail_c;
	logic shvert_c;
	always_comb begin
		jv = int'(j_q);
		shvert_c = vert_q;
		step_c = shvert_c ? (req_q.shift_forward ? -1 : 1) : (req_q.shift_forward ? 1 : -1);
		lead_c = (step_c > 0) ? (ROD_LEN - HALF) : (-HALF - 1);
		tail_c = (step_c > 0) ? (-HALF) : (ROD_LEN - 1 - HALF);
		addr2_c = '0;
		if (state_q == S_SHCHK || state_q == S_SHWR) begin
			addr_c = vert_q ? {wr(pr_q, lead_c), pc_q} : {pr_q, wc(pc_q, lead_c)};
			addr2_c = vert_q ? {wr(pr_q, tail_c), pc_q} : {pr_q, wc(pc_q, tail_c)};
		end else if (!req_q.action) begin
			addr_c = vert_q ? {wr(pr_q, jv), pc_q} : {pr_q, wc(pc_q, jv)};
		end else begin
			// rotation: perpendicular (new) cell when phase 0, old axis cell when phase 1
			if (vert_q ^ phase_q)
				addr_c = {pr_q, wc(pc_q, jv)};
			else
				addr_c = {wr(pr_q, jv), pc_q};
		end
	end

	// head wrap as a constant table over all head values
	logic [RW-1:0] hr_c;
	logic [CW-1:0] hc_c;
	always_comb begin
		hr_c = '0;
		hc_c = '0;
		for (int i = 0; i < HEADS; i++) begin
			if (int'(req_q.head_row) == i) hr_c = RW'(i % ROWS);
			if (int'(req_q.head_col) == i) hc_c = CW'(i % COLS);
		end
	end

	logic signed [JW-1:0] jlo, jhi;
	always_comb begin
		jlo = req_q.action ? JW'(-HALF) : '0;
		jhi = req_q.action ? JW'(ROD_LEN - 1 - HALF) : JW'(ROD_LEN - 1);
	end

	logic [TW-1:0] tag_c;
	assign tag_c = TW'(id_q) + TW'(1);

	always_comb begin
		cwe = 1'b0;
		cwa = addr_c;
		cwd = '0;
		cra = addr_c;
		if (state_q == S_CLEAR) begin
			cwe = 1'b1;
			cwa = clr_q;
		end else if (state_q == S_WRITE) begin
			cwe = 1'b1;
			cwd = (req_q.action && phase_q) ? '0 : tag_c;
		end else if (state_q == S_SHWR) begin
			cwe = 1'b1;
			cwa = phase_q ? addr2_c : addr_c;
			cwd = phase_q ? '0 : tag_c;
		end
		rra = in_ch.payload.rod_index[IW-1:0];
	end

	logic [RW-1:0] npr_c;
	logic [CW-1:0] npc_c;
	always_comb begin
		npr_c = pr_q;
		npc_c = pc_q;
		if (vert_q) npr_c = wr(pr_q, step_c);
		else npc_c = wc(pc_q, step_c);
	end

	always_comb begin
		rwe = 1'b0;
		rwd = {pr_q, pc_q, vert_q};
		if (state_q == S_DONE && (pl_q || rot_q || sh_q)) rwe = 1'b1;
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.payload = rsp_q;

	logic last_j;
	assign last_j = (j_q == jhi);
	logic signed [JW-1:0] jnext;
	always_comb begin
		jnext = j_q + JW'(1);
		if (req_q.action && jnext == '0) jnext = JW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			hcnt_q <= '0;
			vcnt_q <= '0;
			rcnt_q <= '0;
			pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NC - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						req_q <= in_ch.payload;
						id_q <= in_ch.payload.action ? in_ch.payload.rod_index[IW-1:0]
							: IW'(rcnt_q);
						pl_q <= 1'b0;
						rot_q <= 1'b0;
						sh_q <= 1'b0;
						state_q <= S_RDROD;
					end
				end
				S_RDROD: begin
					blocked_q <= 1'b0;
					pend_q <= 1'b0;
					phase_q <= 1'b0;
					j_q <= jlo;
					if (!req_q.action) begin
						pr_q <= hr_c;
						pc_q <= hc_c;
						vert_q <= req_q.place_vertical;
						if (32'(rcnt_q) >= MAX_RODS) state_q <= S_DONE;
						else state_q <= S_CHECK;
					end else begin
						pr_q <= rrd[RW+CW:CW+1];
						pc_q <= rrd[CW:1];
						vert_q <= rrd[0];
						if (32'(req_q.rod_index) >= 32'(rcnt_q)) state_q <= S_DONE;
						else if (req_q.try_rotate) state_q <= S_CHECK;
						else state_q <= S_SHCHK;
					end
				end
				S_CHECK: begin
					// read at addr_c issued; result arrives next cycle (pend_q)
					pend_q <= !last_j;
					if (pend_q && crd != '0) blocked_q <= 1'b1;
					if (!last_j) j_q <= jnext;
					if (last_j && !pend_q) begin
						// final read in flight; wait for its result
						pend_q <= 1'b1;
						j_q <= jhi;
						phase_q <= 1'b1;
					end
					if (phase_q) begin
						j_q <= jlo;
						phase_q <= 1'b0;
						pend_q <= 1'b0;
						if (blocked_q || crd != '0) begin
							state_q <= req_q.action ? S_SHCHK : S_DONE;
						end else begin
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					if (!req_q.action) begin
						if (last_j) begin
							pl_q <= 1'b1;
							pr_q <= vert_q ? wr(pr_q, HALF) : pr_q;
							pc_q <= vert_q ? pc_q : wc(pc_q, HALF);
							rcnt_q <= rcnt_q + CNTW'(1);
							if (vert_q) vcnt_q <= vcnt_q + CNTW'(1);
							else hcnt_q <= hcnt_q + CNTW'(1);
							state_q <= S_DONE;
						end else j_q <= jnext;
					end else begin
						phase_q <= !phase_q;
						if (phase_q) begin
							if (last_j) begin
								rot_q <= 1'b1;
								vert_q <= !vert_q;
								if (vert_q) begin
									vcnt_q <= vcnt_q - CNTW'(1);
									hcnt_q <= hcnt_q + CNTW'(1);
								end else begin
									hcnt_q <= hcnt_q - CNTW'(1);
									vcnt_q <= vcnt_q + CNTW'(1);
								end
								phase_q <= 1'b0;
								pend_q <= 1'b0;
								state_q <= S_SHCHK;
							end else j_q <= jnext;
						end
					end
				end
				S_SHCHK: begin
					pend_q <= 1'b1;
					phase_q <= 1'b0;
					if (pend_q) begin
						pend_q <= 1'b0;
						state_q <= (crd != '0) ? S_DONE : S_SHWR;
					end
				end
				S_SHWR: begin
					phase_q <= 1'b1;
					if (phase_q) begin
						sh_q <= 1'b1;
						pr_q <= npr_c;
						pc_q <= npc_c;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					rsp_q.placed <= pl_q;
					rsp_q.rotated <= rot_q;
					rsp_q.shifted <= sh_q;
					rsp_q.bad_index <= req_q.action && (32'(req_q.rod_index) >= 32'(rcnt_q));
					rsp_q.horizontal_total <= hcnt_q;
					rsp_q.vertical_total <= vcnt_q;
					rsp_q.rod_total <= rcnt_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ch.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		hcnt_q + vcnt_q == rcnt_q) else $error("rod counts out of step");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid) else $error("input taken while result pending");
	a_rot_shift_move: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.payload.rotated || out_ch.payload.shifted))
		|-> !out_ch.payload.placed) else $error("place item reports motion");
`endif
endmodule
